>>> design/csat_pkg.sv
// shared types and constants for the chunk streaming access tracker
package csat_pkg;

    localparam int TAG_W     = 32;
    localparam int CYCLE_W   = 48;
    localparam int OFFSET_W  = 5;
    localparam int BLOCK_W   = 6;
    localparam int TIMEOUT_W = 20;
    localparam int TOTAL_W   = 6;

    typedef enum logic {
        CMD_ACCESS = 1'b0,
        CMD_CHECK  = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [TAG_W-1:0]   tag;
        logic [BLOCK_W-1:0] block;
        logic [CYCLE_W-1:0] cycle;
    } req_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_status_t;

endpackage

>>> design/csat_front.sv
// front end: request acceptance, command decode and block offset folding
module csat_front
    import csat_pkg::*;
#(
    parameter int BLOCKS_PER_CHUNK = 32
) (
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                command,
    input  logic [TAG_W-1:0]    chunk_tag,
    input  logic [OFFSET_W-1:0] block_offset,
    input  logic [CYCLE_W-1:0]  cycle,
    input  q_status_t           q_status,
    output logic                push,
    output req_t                push_req
);

    localparam int RAW_N = 1 << OFFSET_W;

    logic [BLOCK_W-1:0] mod_tab [RAW_N];

    for (genvar i = 0; i < RAW_N; i++) begin : g_mod
        localparam int unsigned M = i % BLOCKS_PER_CHUNK;
        assign mod_tab[i] = BLOCK_W'(M);
    end

    assign in_stall = q_status.full;
    assign push     = in_valid && !q_status.full;

    always_comb
    begin
        push_req.cmd   = (command == 1'b1) ? CMD_CHECK : CMD_ACCESS;
        push_req.tag   = chunk_tag;
        push_req.block = mod_tab[block_offset];
        push_req.cycle = cycle;
    end

endmodule

>>> design/csat_queue.sv
// two-entry request queue between front and back
module csat_queue
    import csat_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  req_t      push_req,
    input  logic      pop,
    output req_t      head,
    output q_status_t q_status
);

    req_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign do_push = push && (count_reg != 2'd2);
    assign do_pop  = pop && (count_reg != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (do_push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_req;
    end

    assign head           = slot_reg[rd_ptr_reg];
    assign q_status.valid = (count_reg != 2'd0);
    assign q_status.full  = (count_reg == 2'd2);

endmodule

>>> design/csat_back.sv
// back end: tracker table, block bitmap memory, check scan and verdict output
module csat_back
    import csat_pkg::*;
#(
    parameter int NUM_TRACKERS     = 8,
    parameter int BLOCKS_PER_CHUNK = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [TIMEOUT_W-1:0] cfg_data,
    input  q_status_t            q_status,
    input  req_t                 head,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [TAG_W-1:0]     verdict_tag,
    output logic                 streaming,
    output logic                 last
);

    localparam int IDX_W = (NUM_TRACKERS > 1) ? $clog2(NUM_TRACKERS) : 1;
    localparam int OFF_W = $clog2(BLOCKS_PER_CHUNK);
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(6000);
    localparam logic [TOTAL_W-1:0]   TOTAL_MAX     = TOTAL_W'(63);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_EVICT = 6'b000010,
        ST_EMIT  = 6'b000100,
        ST_UPD   = 6'b001000,
        ST_CHECK = 6'b010000,
        ST_FLUSH = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [IDX_W-1:0]       min_idx_reg, min_idx_next;
    logic [CYCLE_W-1:0]     min_start_reg, min_start_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [TAG_W-1:0]       pend_tag_reg, pend_tag_next;
    logic                   pend_stream_reg, pend_stream_next;
    logic [TIMEOUT_W-1:0]   timeout_reg;

    logic [TAG_W-1:0]       work_tag_reg;
    logic [CYCLE_W-1:0]     work_cyc_reg;
    logic [BLOCK_W-1:0]     work_block_reg;

    logic                   out_valid_reg;
    logic [TAG_W-1:0]       out_tag_reg;
    logic                   out_stream_reg;
    logic                   out_last_reg;

    logic [NUM_TRACKERS-1:0] valid_reg;
    logic [NUM_TRACKERS-1:0] dup_reg;
    logic [NUM_TRACKERS-1:0] clean_reg;
    logic [TAG_W-1:0]        tag_reg   [NUM_TRACKERS];
    logic [CYCLE_W-1:0]      start_reg [NUM_TRACKERS];
    logic [TOTAL_W-1:0]      total_reg [NUM_TRACKERS];

    logic [BLOCKS_PER_CHUNK-1:0] seen_mem [NUM_TRACKERS];
    logic [BLOCKS_PER_CHUNK-1:0] rd_row_reg;
    logic [BLOCKS_PER_CHUNK-1:0] cur_row;
    logic [BLOCKS_PER_CHUNK-1:0] bit_mask;
    logic [OFF_W-1:0]            cur_off;
    logic                        seen_bit;

    logic [NUM_TRACKERS-1:0] hit_vec;
    logic                    hit_any;
    logic [IDX_W-1:0]        hit_idx;
    logic                    free_any;
    logic [IDX_W-1:0]        free_idx;

    logic                    out_free;
    logic                    out_load;
    logic [TAG_W-1:0]        load_tag;
    logic                    load_stream;
    logic                    load_last;
    logic                    reload_en;
    logic [IDX_W-1:0]        reload_idx;
    logic [TAG_W-1:0]        reload_tag;
    logic [CYCLE_W-1:0]      reload_cycle;
    logic                    upd_en;
    logic                    clr_en;
    logic                    scan_last;
    logic [CYCLE_W-1:0]      age;
    logic                    judge_bad;
    logic                    judge_good;

    assign out_free  = !out_valid_reg || !out_stall;
    assign scan_last = (idx_reg == IDX_W'(NUM_TRACKERS - 1));
    assign age       = work_cyc_reg - start_reg[idx_reg];
    assign judge_bad = (age > CYCLE_W'(timeout_reg)) || dup_reg[idx_reg];
    assign judge_good = ({1'b0, total_reg[idx_reg]} == (TOTAL_W + 1)'(BLOCKS_PER_CHUNK));

    assign cur_off  = work_block_reg[OFF_W-1:0];
    assign cur_row  = clean_reg[idx_reg] ? '0 : rd_row_reg;
    assign bit_mask = {{(BLOCKS_PER_CHUNK - 1){1'b0}}, 1'b1} << cur_off;
    assign seen_bit = cur_row[cur_off];

    // parallel tag match and lowest free slot
    always_comb
    begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int t = NUM_TRACKERS - 1; t >= 0; t--)
        begin
            hit_vec[t] = valid_reg[t] && (tag_reg[t] == head.tag);
            if (hit_vec[t])
            begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(t);
            end
            if (!valid_reg[t])
            begin
                free_any = 1'b1;
                free_idx = IDX_W'(t);
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        min_idx_next     = min_idx_reg;
        min_start_next   = min_start_reg;
        pend_valid_next  = pend_valid_reg;
        pend_tag_next    = pend_tag_reg;
        pend_stream_next = pend_stream_reg;
        pop              = 1'b0;
        out_load         = 1'b0;
        load_tag         = pend_tag_reg;
        load_stream      = pend_stream_reg;
        load_last        = 1'b1;
        reload_en        = 1'b0;
        reload_idx       = idx_reg;
        reload_tag       = work_tag_reg;
        reload_cycle     = work_cyc_reg;
        upd_en           = 1'b0;
        clr_en           = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_status.valid)
                begin
                    pop = 1'b1;
                    if (head.cmd == CMD_ACCESS)
                    begin
                        if (hit_any)
                        begin
                            idx_next   = hit_idx;
                            state_next = ST_UPD;
                        end
                        else if (free_any)
                        begin
                            reload_en    = 1'b1;
                            reload_idx   = free_idx;
                            reload_tag   = head.tag;
                            reload_cycle = head.cycle;
                            idx_next     = free_idx;
                            state_next   = ST_UPD;
                        end
                        else
                        begin
                            idx_next       = '0;
                            min_idx_next   = '0;
                            min_start_next = '1;
                            state_next     = ST_EVICT;
                        end
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_EVICT:
            begin
                if (start_reg[idx_reg] < min_start_reg)
                begin
                    min_idx_next   = idx_reg;
                    min_start_next = start_reg[idx_reg];
                end
                if (scan_last)
                begin
                    idx_next   = min_idx_next;
                    state_next = ST_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load    = 1'b1;
                    load_tag    = tag_reg[idx_reg];
                    load_stream = 1'b0;
                    load_last   = 1'b1;
                    reload_en   = 1'b1;
                    state_next  = ST_UPD;
                end
            end
            ST_UPD:
            begin
                upd_en     = 1'b1;
                state_next = ST_IDLE;
            end
            ST_CHECK:
            begin
                if (!(valid_reg[idx_reg] && (judge_bad || judge_good)
                      && pend_valid_reg && !out_free))
                begin
                    if (valid_reg[idx_reg] && (judge_bad || judge_good))
                    begin
                        clr_en = 1'b1;
                        if (pend_valid_reg)
                        begin
                            out_load  = 1'b1;
                            load_last = 1'b0;
                        end
                        pend_valid_next  = 1'b1;
                        pend_tag_next    = tag_reg[idx_reg];
                        pend_stream_next = !judge_bad;
                    end
                    if (scan_last)
                        state_next = ST_FLUSH;
                    else
                        idx_next = idx_reg + 1'b1;
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_load        = 1'b1;
                    load_last       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            min_idx_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            timeout_reg    <= TIMEOUT_RESET;
            valid_reg      <= '0;
            dup_reg        <= '0;
            clean_reg      <= '1;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            min_idx_reg    <= min_idx_next;
            pend_valid_reg <= pend_valid_next;
            if (cfg_valid)
                timeout_reg <= cfg_data;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (reload_en)
            begin
                valid_reg[reload_idx] <= 1'b1;
                dup_reg[reload_idx]   <= 1'b0;
                clean_reg[reload_idx] <= 1'b1;
            end
            if (upd_en)
            begin
                dup_reg[idx_reg]   <= dup_reg[idx_reg] | seen_bit;
                clean_reg[idx_reg] <= 1'b0;
            end
            if (clr_en)
                valid_reg[idx_reg] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        min_start_reg   <= min_start_next;
        pend_tag_reg    <= pend_tag_next;
        pend_stream_reg <= pend_stream_next;
        if (pop)
        begin
            work_tag_reg   <= head.tag;
            work_cyc_reg   <= head.cycle;
            work_block_reg <= head.block;
        end
        if (out_load)
        begin
            out_tag_reg    <= load_tag;
            out_stream_reg <= load_stream;
            out_last_reg   <= load_last;
        end
        if (reload_en)
        begin
            tag_reg[reload_idx]   <= reload_tag;
            start_reg[reload_idx] <= reload_cycle;
            total_reg[reload_idx] <= '0;
        end
        if (upd_en && (total_reg[idx_reg] != TOTAL_MAX))
            total_reg[idx_reg] <= total_reg[idx_reg] + 1'b1;
    end

    // block bitmap memory
    always_ff @(posedge clk)
    begin
        if (upd_en)
            seen_mem[idx_reg] <= cur_row | bit_mask;
        rd_row_reg <= seen_mem[idx_next];
    end

    assign out_valid   = out_valid_reg;
    assign verdict_tag = out_tag_reg;
    assign streaming   = out_stream_reg;
    assign last        = out_last_reg;

    a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(hit_vec) <= 1)
        else $error("two valid trackers hold the same tag");

    a_upd_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD) |-> valid_reg[idx_reg])
        else $error("block update on an invalid tracker");

    a_pend_scope: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == ST_CHECK || state_reg == ST_FLUSH))
        else $error("pending verdict outside a check");

    a_nonlast_scope: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg)
            |-> (state_reg == ST_CHECK || state_reg == ST_FLUSH))
        else $error("non-final verdict left behind by a finished request");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == ST_IDLE))
        else $error("request popped while busy");

endmodule

>>> design/chunk_streaming_access_tracker.sv
// top level of the chunk streaming access tracker
//
// Requests enter a two-entry queue and are carried out one at a time by the
// tracker sequencer. An access that hits a tracker or finds a free one does a
// lookup, then a read-modify-write of the block bitmap memory. An access that
// must evict scans the start cycles one tracker per cycle, then emits the
// victim's verdict when the output is free. A check walks the trackers one
// per cycle, pausing while a verdict waits on out_stall; its final verdict
// carries last. A request is accepted while results wait at the output, as
// long as the queue has room. The timeout register is to be written through
// cfg_data only while the block is idle; the block itself does not enforce it.
module chunk_streaming_access_tracker
    import csat_pkg::*;
#(
    parameter int NUM_TRACKERS     = 8,
    parameter int BLOCKS_PER_CHUNK = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 command,
    input  logic [TAG_W-1:0]     chunk_tag,
    input  logic [OFFSET_W-1:0]  block_offset,
    input  logic                 is_write,
    input  logic [CYCLE_W-1:0]   cycle,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [TAG_W-1:0]     verdict_tag,
    output logic                 streaming,
    output logic                 last,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [TIMEOUT_W-1:0] cfg_data
);

    q_status_t q_status;
    logic      push;
    req_t      push_req;
    logic      pop;
    req_t      head;
    logic      unused_write;

    // write flag has no effect on tracking
    assign unused_write = is_write;
    assign cfg_ready    = 1'b1;

    csat_front #(
        .BLOCKS_PER_CHUNK(BLOCKS_PER_CHUNK)
    ) u_front (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .chunk_tag   (chunk_tag),
        .block_offset(block_offset),
        .cycle       (cycle),
        .q_status    (q_status),
        .push        (push),
        .push_req    (push_req)
    );

    csat_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_req(push_req),
        .pop     (pop),
        .head    (head),
        .q_status(q_status)
    );

    csat_back #(
        .NUM_TRACKERS    (NUM_TRACKERS),
        .BLOCKS_PER_CHUNK(BLOCKS_PER_CHUNK)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .q_status   (q_status),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .verdict_tag(verdict_tag),
        .streaming  (streaming),
        .last       (last)
    );

endmodule

>>> tb/tb_top.sv
// self-checking testbench for chunk_streaming_access_tracker: random requests, predicted verdicts
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import csat_pkg::*;

    localparam int NUM_TRK    = 8;
    localparam int BLOCKS     = 32;
    localparam int POOL       = 6;
    localparam int PHASES     = 8;
    localparam int PHASE_REQS = 30;
    localparam int SETTLE     = 40;
    localparam int QUIET_MAX  = 5000;

    typedef struct {
        cmd_t                cmd;
        logic [TAG_W-1:0]    tag;
        logic [OFFSET_W-1:0] offset;
        logic                wr;
        logic [CYCLE_W-1:0]  cyc;
    } tracker_req_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic             streaming;
        logic             last;
    } verdict_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 in_valid     = 1'b0;
    logic                 in_stall;
    logic                 command      = 1'b0;
    logic [TAG_W-1:0]     chunk_tag    = '0;
    logic [OFFSET_W-1:0]  block_offset = '0;
    logic                 is_write     = 1'b0;
    logic [CYCLE_W-1:0]   cycle        = '0;
    logic                 out_valid;
    logic                 out_stall    = 1'b0;
    logic [TAG_W-1:0]     verdict_tag;
    logic                 streaming;
    logic                 last;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [TIMEOUT_W-1:0] cfg_data     = '0;

    // tracker table as the block should hold it
    logic                 trk_valid [NUM_TRK];
    logic [TAG_W-1:0]     trk_tag   [NUM_TRK];
    logic [CYCLE_W-1:0]   trk_start [NUM_TRK];
    logic [TOTAL_W-1:0]   trk_total [NUM_TRK];
    logic [1:0]           trk_hits  [NUM_TRK][BLOCKS];
    logic [TIMEOUT_W-1:0] timeout_now = 20'd6000;

    tracker_req_t pending_reqs [$];
    tracker_req_t cur_req;
    verdict_t     expected_verdicts [$];
    logic [TAG_W-1:0]   pool_tags [POOL];
    logic [CYCLE_W-1:0] now_cyc;

    int idle_pct      = 0;
    int stall_pct     = 0;
    int queued_reqs   = 0;
    int reqs_accepted = 0;
    int verdicts_seen = 0;
    int streams_seen  = 0;
    int error_count   = 0;
    int quiet_cycles  = 0;

    chunk_streaming_access_tracker #(
        .NUM_TRACKERS     (NUM_TRK),
        .BLOCKS_PER_CHUNK (BLOCKS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .chunk_tag    (chunk_tag),
        .block_offset (block_offset),
        .is_write     (is_write),
        .cycle        (cycle),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .verdict_tag  (verdict_tag),
        .streaming    (streaming),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic void clear_tracker(int t);
        trk_valid[t] = 1'b0;
        trk_tag[t]   = '0;
        trk_start[t] = '0;
        trk_total[t] = '0;
        for (int b = 0; b < BLOCKS; b++)
            trk_hits[t][b] = 2'd0;
    endfunction

    function automatic void predict_verdicts(tracker_req_t r);
        int                 sel;
        int                 n;
        int                 blk;
        logic               hit;
        logic               bad;
        logic [CYCLE_W-1:0] age;
        verdict_t           v;
        sel = -1;
        n   = 0;
        hit = 1'b0;
        if (r.cmd == CMD_ACCESS)
        begin
            for (int t = 0; t < NUM_TRK; t++)
                if (sel < 0 && trk_valid[t] && trk_tag[t] == r.tag)
                begin
                    sel = t;
                    hit = 1'b1;
                end
            if (!hit)
                for (int t = 0; t < NUM_TRK; t++)
                    if (sel < 0 && !trk_valid[t])
                        sel = t;
            if (sel < 0)
            begin
                // eviction: oldest start cycle, lowest index on a tie
                sel = 0;
                for (int t = 1; t < NUM_TRK; t++)
                    if (trk_start[t] < trk_start[sel])
                        sel = t;
                expected_verdicts.push_back('{trk_tag[sel], 1'b0, 1'b0});
                n++;
            end
            if (!hit)
            begin
                clear_tracker(sel);
                trk_valid[sel] = 1'b1;
                trk_tag[sel]   = r.tag;
                trk_start[sel] = r.cyc;
            end
            blk = int'(r.offset) % BLOCKS;
            if (trk_total[sel] != '1)
                trk_total[sel] = trk_total[sel] + 1'b1;
            if (trk_hits[sel][blk] != 2'd3)
                trk_hits[sel][blk] = trk_hits[sel][blk] + 2'd1;
        end
        else
        begin
            for (int t = 0; t < NUM_TRK; t++)
            begin
                if (trk_valid[t])
                begin
                    age = r.cyc - trk_start[t];
                    bad = age > CYCLE_W'(timeout_now);
                    for (int b = 0; b < BLOCKS; b++)
                        if (trk_hits[t][b] > 2'd1)
                            bad = 1'b1;
                    if (bad)
                    begin
                        expected_verdicts.push_back('{trk_tag[t], 1'b0, 1'b0});
                        n++;
                        clear_tracker(t);
                    end
                    else if (trk_total[t] == TOTAL_W'(BLOCKS))
                    begin
                        expected_verdicts.push_back('{trk_tag[t], 1'b1, 1'b0});
                        n++;
                        clear_tracker(t);
                    end
                end
            end
        end
        if (n > 0)
        begin
            v = expected_verdicts.pop_back();
            v.last = 1'b1;
            expected_verdicts.push_back(v);
        end
    endfunction

    function automatic void flag_error(string msg);
        error_count++;
        if (error_count <= 10)
            $display("[%0t] %s", $time, msg);
    endfunction

    function automatic void push_req(input cmd_t cmd, input logic [TAG_W-1:0] tag,
                                     input logic [OFFSET_W-1:0] offset,
                                     input logic [CYCLE_W-1:0] cyc);
        tracker_req_t r;
        r.cmd    = cmd;
        r.tag    = tag;
        r.offset = offset;
        r.wr     = 1'($urandom());
        r.cyc    = cyc;
        pending_reqs.push_back(r);
        queued_reqs++;
    endfunction

    task automatic drain();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || in_valid || expected_verdicts.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            command      <= 1'b0;
            chunk_tag    <= '0;
            block_offset <= '0;
            is_write     <= 1'b0;
            cycle        <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_verdicts(cur_req);
                reqs_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    cur_req = pending_reqs.pop_front();
                    in_valid     <= 1'b1;
                    command      <= cur_req.cmd;
                    chunk_tag    <= cur_req.tag;
                    block_offset <= cur_req.offset;
                    is_write     <= cur_req.wr;
                    cycle        <= cur_req.cyc;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // verdict monitor
    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        verdict_t got;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = '{verdict_tag, streaming, last};
                verdicts_seen++;
                if (streaming)
                    streams_seen++;
                if (expected_verdicts.size() == 0)
                    flag_error($sformatf("unexpected verdict: tag %h streaming %b last %b",
                                         got.tag, got.streaming, got.last));
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (got.tag !== want.tag || got.streaming !== want.streaming
                        || got.last !== want.last)
                        flag_error($sformatf({"verdict mismatch: expected tag %h streaming %b",
                                              " last %b, got tag %h streaming %b last %b"},
                                             want.tag, want.streaming, want.last,
                                             got.tag, got.streaming, got.last));
                end
            end
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_MAX)
        begin
            $display("tb_top: errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int                   p;
        int                   n;
        int                   i;
        int                   j;
        int                   tmp;
        int                   kind;
        int                   pick;
        int                   step;
        int                   phase_base;
        int                   order [BLOCKS+1];
        logic [TAG_W-1:0]     tag;
        logic [CYCLE_W-1:0]   start;
        logic [CYCLE_W-1:0]   age;
        logic [CYCLE_W-1:0]   span;
        logic [CYCLE_W-1:0]   limit;
        logic [TIMEOUT_W-1:0] plan [PHASES];

        plan = '{20'd6000, 20'd0, 20'hFFFFF, 20'd100,
                 TIMEOUT_W'($urandom_range(64, 20'hFFFFF)), 20'd1, 20'd40,
                 TIMEOUT_W'($urandom())};
        for (int t = 0; t < NUM_TRK; t++)
            clear_tracker(t);
        for (int k = 0; k < POOL; k++)
            pool_tags[k] = $urandom();
        now_cyc = 48'd1000;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (p = 0; p < PHASES; p++)
        begin
            drain();
            case (p % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 46;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 46;
                end
                default:
                begin
                    idle_pct  = 22;
                    stall_pct = 22;
                end
            endcase

            @(posedge clk);
            cfg_valid <= 1'b1;
            cfg_data  <= plan[p];
            do
                @(posedge clk);
            while (!cfg_ready);
            cfg_valid <= 1'b0;
            timeout_now = plan[p];
            @(negedge clk);
            phase_base = queued_reqs;

            if (p == 0)
            begin
                // field extremes, repeated block, fill, two evictions, checks across wrap
                push_req(CMD_ACCESS, 32'h0, 5'd0, 48'h0);
                push_req(CMD_ACCESS, 32'hFFFF_FFFF, 5'd31, 48'hFFFF_FFFF_FFFF);
                push_req(CMD_ACCESS, 32'h0, 5'd0, 48'd5);
                for (int k = 1; k <= 6; k++)
                    push_req(CMD_ACCESS, TAG_W'(k), OFFSET_W'(k), CYCLE_W'(9 + k));
                push_req(CMD_ACCESS, 32'd7, 5'd7, 48'd20);
                push_req(CMD_ACCESS, 32'd8, 5'd8, 48'd21);
                push_req(CMD_CHECK, 32'hFFFF_FFFF, 5'd31, 48'd100);
                push_req(CMD_CHECK, 32'h0, 5'd0, 48'hFFFF_FFFF_FFFF);
                push_req(CMD_ACCESS, 32'hFFFF_FFFF, 5'd31, 48'd6);
                push_req(CMD_CHECK, 32'h0, 5'd0, 48'd7);
                push_req(CMD_CHECK, 32'h0, 5'd0, 48'd8);
            end

            while (queued_reqs - phase_base < PHASE_REQS)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 55)
                begin
                    // one chunk walked block by block, sometimes flawed, then a check
                    tag = $urandom();
                    for (i = 0; i < BLOCKS; i++)
                        order[i] = i;
                    for (i = BLOCKS - 1; i > 0; i--)
                    begin
                        j = $urandom_range(0, i);
                        tmp = order[i];
                        order[i] = order[j];
                        order[j] = tmp;
                    end
                    order[BLOCKS] = order[$urandom_range(0, BLOCKS - 1)];
                    pick = $urandom_range(0, 9);
                    n = (pick == 8) ? BLOCKS - 1 : (pick == 9) ? BLOCKS + 1 : BLOCKS;
                    if (pick == 7)
                        order[BLOCKS-1] = order[0];
                    step = (timeout_now >= 64) ? $urandom_range(0, 2) : 0;
                    start = now_cyc;
                    for (i = 0; i < n; i++)
                    begin
                        push_req(CMD_ACCESS, tag, OFFSET_W'(order[i]),
                                 start + CYCLE_W'(step * i));
                        if ($urandom_range(0, 9) == 0)
                            push_req(CMD_ACCESS, pool_tags[$urandom_range(0, POOL - 1)],
                                     OFFSET_W'($urandom()), start + CYCLE_W'(step * i));
                    end
                    span = CYCLE_W'(step * (n - 1));
                    pick = $urandom_range(0, 9);
                    if (pick < 5)
                        age = span;
                    else if (pick < 7)
                    begin
                        limit = CYCLE_W'(timeout_now) - span;
                        if (limit > CYCLE_W'(200))
                            limit = CYCLE_W'(200);
                        age = span + CYCLE_W'($urandom_range(0, int'(limit)));
                    end
                    else if (pick == 7)
                        age = CYCLE_W'(timeout_now);
                    else if (pick == 8)
                        age = CYCLE_W'(timeout_now) + 48'd1;
                    else
                        age = span + CYCLE_W'($urandom_range(0, 3));
                    push_req(CMD_CHECK, $urandom(), OFFSET_W'($urandom()), start + age);
                    now_cyc = start + age + CYCLE_W'($urandom_range(1, 5));
                end
                else if (kind < 78)
                begin
                    // scattered traffic with cycle jumps and wrap
                    n = $urandom_range(5, 15);
                    repeat (n)
                    begin
                        pick = $urandom_range(0, 99);
                        if (pick < 12)
                            push_req(CMD_CHECK, $urandom(), OFFSET_W'($urandom()), now_cyc);
                        else if (pick < 65)
                            push_req(CMD_ACCESS, pool_tags[$urandom_range(0, POOL - 1)],
                                     OFFSET_W'($urandom()), now_cyc);
                        else
                            push_req(CMD_ACCESS, $urandom(), OFFSET_W'($urandom()), now_cyc);
                        now_cyc = now_cyc + CYCLE_W'($urandom_range(0, 3));
                        pick = $urandom_range(0, 59);
                        if (pick == 0)
                            now_cyc = {16'($urandom()), $urandom()};
                        else if (pick == 1)
                            now_cyc = 48'hFFFF_FFFF_FFFF - CYCLE_W'($urandom_range(0, 40));
                    end
                end
                else if (kind < 95)
                begin
                    // fresh tags until trackers get evicted, equal start cycles included
                    n = $urandom_range(9, 12);
                    repeat (n)
                    begin
                        push_req(CMD_ACCESS, $urandom(), OFFSET_W'($urandom()), now_cyc);
                        now_cyc = now_cyc + CYCLE_W'($urandom_range(0, 1));
                    end
                    if ($urandom_range(0, 1) == 1)
                        push_req(CMD_CHECK, $urandom(), OFFSET_W'($urandom()), now_cyc);
                end
                else
                begin
                    // one chunk hammered past the saturation of its totals
                    tag = $urandom();
                    n = $urandom_range(64, 68);
                    repeat (n)
                        push_req(CMD_ACCESS, tag, OFFSET_W'($urandom()), now_cyc);
                    push_req(CMD_CHECK, $urandom(), OFFSET_W'($urandom()), now_cyc);
                    now_cyc = now_cyc + 48'd1;
                end
            end
        end

        drain();
        $display("tb_top: %0d requests, %0d verdicts compared, %0d of them streaming",
                 reqs_accepted, verdicts_seen, streams_seen);
        $display("tb_top: %0d timeout settings over four idle patterns, %0d mismatches",
                 PHASES, error_count);
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

>>> filelist.f
design/csat_pkg.sv
design/csat_front.sv
design/csat_queue.sv
design/csat_back.sv
design/chunk_streaming_access_tracker.sv
tb/tb_top.sv
